// ===== sv/cacsp_pkg.sv =====
// Shared types and constants for the cave smoothing pass.
package cacsp_pkg;

  // Field and register widths
  localparam int COL_W  = 10;
  localparam int ROW_W  = 10;
  localparam int CFG_W  = 11;
  localparam int THR_W  = 4;
  localparam int IDX_W  = 2;
  localparam int CNT9_W = 4;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_GRID_WIDTH     = 2'd0;
  localparam logic [IDX_W-1:0] REG_GRID_HEIGHT    = 2'd1;
  localparam logic [IDX_W-1:0] REG_WALL_THRESHOLD = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_GRID_WIDTH     = 11'd80;
  localparam logic [CFG_W-1:0] RST_GRID_HEIGHT    = 11'd50;
  localparam logic [THR_W-1:0] RST_WALL_THRESHOLD = 4'd5;

  // Grid limits
  localparam logic [CFG_W-1:0] MIN_DIM      = 11'd3;
  localparam logic [CFG_W-1:0] HEIGHT_LIMIT = 11'd1024;

  // Window: all cells but the centre
  localparam logic [8:0] RING_MASK = 9'h1EF;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef logic [QCNT_W-1:0] qcnt_t;

  // One classified input: up to two result words
  typedef struct packed {
    logic             int_v;
    logic             int_wall;
    logic [COL_W-1:0] int_col;
    logic [ROW_W-1:0] int_row;
    logic             brd_v;
    logic             brd_wall;
    logic [COL_W-1:0] brd_col;
    logic [ROW_W-1:0] brd_row;
  } entry_t;

endpackage

// ===== sv/cellular_automaton_smoothing_pass.sv =====
// Top level of the cave smoothing pass: front end, queue and back end.
//
// Usage: write grid_width, grid_height and wall_threshold on the cfg_ port
// while the block is idle; any write of a known index starts a new grid.
// Stream the grid in raster order on in_valid / in_cell_wall, one cell a word.
// Each cell yields zero to two result words (column, row, new state), the
// last one for that cell flagged by out_run_last; every cell of the grid gets
// exactly one result, interior cells one row and one column late.
// Throughput: one cell per cycle at the input while in_stall is low; the
// output register sends one result word per cycle while out_stall is low,
// so a cell with two results sends them in turn. Each result word is formed in
// stage 1 (line store read) and passes the queue and the output register.
// in_stall rises when the words in the four-word queue and in stage 1 add up
// to four; out_stall backs up the queue only, and the input goes on till full.
// Reset restores the register defaults and the start of grid; the line
// stores are not cleared, as rows 0 and 1 never reach an interior result.
module cellular_automaton_smoothing_pass #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [cacsp_pkg::IDX_W-1:0] cfg_index,
  input  logic [cacsp_pkg::CFG_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_cell_wall,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cacsp_pkg::COL_W-1:0] out_col,
  output logic [cacsp_pkg::ROW_W-1:0] out_row,
  output logic                        out_wall,
  output logic                        out_run_last
);
  import cacsp_pkg::*;

  logic   push, pop, q_empty;
  entry_t push_entry, q_head;
  qcnt_t  q_cnt;

  // Position, line stores, window and classification
  cacsp_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cell_wall (in_cell_wall),
    .q_cnt        (q_cnt),
    .push         (push),
    .push_entry   (push_entry)
  );

  // Decoupling queue
  cacsp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (q_head),
    .empty      (q_empty),
    .cnt        (q_cnt)
  );

  // Result sequencing and output register
  cacsp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (q_head),
    .empty        (q_empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_col      (out_col),
    .out_row      (out_row),
    .out_wall     (out_wall),
    .out_run_last (out_run_last)
  );

endmodule

// ===== sv/cacsp_front.sv =====
// Front end: config registers, raster position, line stores, 3x3 window and classification.
module cacsp_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cacsp_pkg::IDX_W-1:0]   cfg_index,
  input  logic [cacsp_pkg::CFG_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cell_wall,
  input  cacsp_pkg::qcnt_t              q_cnt,
  output logic                          push,
  output cacsp_pkg::entry_t             push_entry
);
  import cacsp_pkg::*;

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int EXT_W = 14;
  localparam logic [EXT_W-1:0] MAXW_EXT = EXT_W'(MAX_WIDTH);

  // Config registers
  logic [CFG_W-1:0] grid_width_r, grid_height_r;
  logic [THR_W-1:0] wall_threshold_r;
  logic             restart_cfg;

  // Position and window
  logic [AW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [8:0]       win_r, win_nxt;

  // Line stores: bit 1 is previous row, bit 0 the row before it
  logic [1:0]       line_mem [MAX_WIDTH];
  logic [1:0]       rd_r;

  // Stage 1
  logic             s1_v_r;
  logic [AW-1:0]    s1_c_r;
  logic [ROW_W-1:0] s1_row_r;
  logic             s1_bit_r, s1_rst_r, s1_int_r, s1_brd_r;

  logic [WW-1:0]    w_eff;
  logic [CFG_W-1:0] h_eff;
  logic [EXT_W-1:0] gw_ext;
  logic             accept, restart_pos;
  logic [AW-1:0]    c_cur;
  logic [ROW_W-1:0] r_cur;
  logic [WW-1:0]    c_inc;
  logic [CFG_W-1:0] r_inc;
  logic             is_int, is_brd;
  logic [CFG_W:0]   pend;
  logic [2:0]       column;
  logic [8:0]       ring;
  logic [CNT9_W-1:0] ring_cnt;
  logic [AW-1:0]    c_m1;
  logic [ROW_W-1:0] r_m1;

  // Effective dimensions, clamped
  always_comb begin
    gw_ext = EXT_W'(grid_width_r);
    if (gw_ext < EXT_W'(MIN_DIM)) begin
      w_eff = WW'(MIN_DIM);
    end else if (gw_ext > MAXW_EXT) begin
      w_eff = WW'(MAXW_EXT);
    end else begin
      w_eff = WW'(gw_ext);
    end
    if (grid_height_r < MIN_DIM) begin
      h_eff = MIN_DIM;
    end else if (grid_height_r > HEIGHT_LIMIT) begin
      h_eff = HEIGHT_LIMIT;
    end else begin
      h_eff = grid_height_r;
    end
  end

  // Hold off input while the queue may not take what is in flight
  assign pend     = (CFG_W+1)'(q_cnt) + (CFG_W+1)'(s1_v_r);
  assign in_stall = pend >= (CFG_W+1)'(QDEPTH);
  assign accept   = in_valid && !in_stall;

  // Position of this cell and of the next
  always_comb begin
    restart_pos = (WW'(col_r) >= w_eff) || (CFG_W'(row_r) >= h_eff);
    c_cur = restart_pos ? '0 : col_r;
    r_cur = restart_pos ? '0 : row_r;
    is_int = (c_cur >= AW'(2)) && (r_cur >= ROW_W'(2));
    is_brd = (c_cur == '0) || (WW'(c_cur) == w_eff - WW'(1)) ||
             (r_cur == '0) || (CFG_W'(r_cur) == h_eff - CFG_W'(1));
    c_inc = WW'(c_cur) + WW'(1);
    r_inc = CFG_W'(r_cur) + CFG_W'(1);
    col_nxt = c_cur;
    row_nxt = r_cur;
    if (c_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (r_inc >= h_eff) ? '0 : ROW_W'(r_inc);
    end else begin
      col_nxt = AW'(c_inc);
    end
  end

  // Config writes; an unknown index is dropped
  always_comb begin
    restart_cfg = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH, REG_GRID_HEIGHT, REG_WALL_THRESHOLD: restart_cfg = 1'b1;
        default: restart_cfg = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r     <= RST_GRID_WIDTH;
      grid_height_r    <= RST_GRID_HEIGHT;
      wall_threshold_r <= RST_WALL_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:     grid_width_r     <= cfg_data;
        REG_GRID_HEIGHT:    grid_height_r    <= cfg_data;
        REG_WALL_THRESHOLD: wall_threshold_r <= THR_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Window update and interior count in stage 1
  always_comb begin
    column   = {s1_bit_r, rd_r[1], rd_r[0]};
    win_nxt  = {column, (s1_rst_r ? 6'b0 : win_r[8:3])};
    ring     = win_nxt & RING_MASK;
    ring_cnt = '0;
    for (int i = 0; i < 9; i++) begin
      ring_cnt = ring_cnt + CNT9_W'(ring[i]);
    end
    c_m1 = s1_c_r - AW'(1);
    r_m1 = s1_row_r - ROW_W'(1);
  end

  // Position, window and stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      win_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      if (restart_cfg) begin
        col_r <= '0;
        row_r <= '0;
        win_r <= '0;
      end else begin
        if (accept) begin
          col_r <= col_nxt;
          row_r <= row_nxt;
        end
        if (s1_v_r) begin
          win_r <= win_nxt;
        end
      end
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_c_r   <= c_cur;
      s1_row_r <= r_cur;
      s1_bit_r <= in_cell_wall;
      s1_rst_r <= restart_pos;
      s1_int_r <= is_int;
      s1_brd_r <= is_brd;
    end
  end

  // Line store: read on accept, shift rows on the following cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= line_mem[c_cur];
    end
    if (s1_v_r) begin
      line_mem[s1_c_r] <= {s1_bit_r, rd_r[1]};
    end
  end

  // Classified word into the queue
  always_comb begin
    push                = s1_v_r && (s1_int_r || s1_brd_r);
    push_entry.int_v    = s1_int_r;
    push_entry.int_wall = (ring_cnt >= wall_threshold_r);
    push_entry.int_col  = COL_W'(c_m1);
    push_entry.int_row  = r_m1;
    push_entry.brd_v    = s1_brd_r;
    push_entry.brd_wall = s1_bit_r;
    push_entry.brd_col  = COL_W'(s1_c_r);
    push_entry.brd_row  = s1_row_r;
  end

endmodule

// ===== sv/cacsp_queue.sv =====
// Short queue of classified words between front and back.
module cacsp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cacsp_pkg::entry_t push_entry,
  input  logic              pop,
  output cacsp_pkg::entry_t head,
  output logic              empty,
  output cacsp_pkg::qcnt_t  cnt
);
  import cacsp_pkg::*;

  entry_t             q_r [QDEPTH];
  logic [QPTR_W-1:0]  wp_r, rp_r;
  qcnt_t              cnt_r;

  assign head  = q_r[rp_r];
  assign empty = (cnt_r == '0);
  assign cnt   = cnt_r;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + QPTR_W'(1);
      if (pop)  rp_r <= rp_r + QPTR_W'(1);
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_entry;
    end
  end

endmodule

// ===== sv/cacsp_back.sv =====
// Back end: splits queued words into result words and holds the output register.
module cacsp_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cacsp_pkg::entry_t           head,
  input  logic                        empty,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cacsp_pkg::COL_W-1:0] out_col,
  output logic [cacsp_pkg::ROW_W-1:0] out_row,
  output logic                        out_wall,
  output logic                        out_run_last
);
  import cacsp_pkg::*;

  logic             out_valid_r, out_valid_nxt;
  logic             phase_r, phase_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             wall_r, wall_nxt, last_r, last_nxt;
  logic             load, take;

  // Pick the next result word from the head of the queue
  always_comb begin
    load          = !out_valid_r || !out_stall;
    take          = load && !empty;
    pop           = 1'b0;
    phase_nxt     = phase_r;
    out_valid_nxt = load ? take : out_valid_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    wall_nxt      = wall_r;
    last_nxt      = last_r;
    if (take) begin
      if (head.int_v && !phase_r) begin
        col_nxt  = head.int_col;
        row_nxt  = head.int_row;
        wall_nxt = head.int_wall;
        last_nxt = !head.brd_v;
        if (head.brd_v) begin
          phase_nxt = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        col_nxt   = head.brd_col;
        row_nxt   = head.brd_row;
        wall_nxt  = head.brd_wall;
        last_nxt  = 1'b1;
        pop       = 1'b1;
        phase_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r  <= col_nxt;
    row_r  <= row_nxt;
    wall_r <= wall_nxt;
    last_r <= last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_col      = col_r;
  assign out_row      = row_r;
  assign out_wall     = wall_r;
  assign out_run_last = last_r;

endmodule

// ===== tb/tb_cellular_automaton_smoothing_pass.sv =====
// Self-checking testbench for the cave smoothing pass: grids streamed in, words checked out.
`timescale 1ns / 100ps

module tb_cellular_automaton_smoothing_pass;
  import cacsp_pkg::*;

  localparam int MAX_W         = 1024;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int IDLE_PCT      = 30;
  localparam int MAX_REPORTS   = 40;
  localparam int RANDOM_CELLS  = 60;
  localparam int RESET_CELLS   = 90;
  localparam int WIDE_CELLS    = 20;
  localparam int TALL_CELLS    = 15;
  // No register lives at this index
  localparam logic [IDX_W-1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             wall;
    logic             last;
  } cell_update_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_stall;
  logic             in_cell_wall;
  logic             out_valid;
  logic             out_stall;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  logic             out_wall;
  logic             out_run_last;

  // Expected result words, oldest first
  cell_update_t pending_updates[$];

  // Predictor copy of registers and grid state
  logic [CFG_W-1:0] grid_w_reg;
  logic [CFG_W-1:0] grid_h_reg;
  logic [THR_W-1:0] thresh_reg;
  bit               line_recent [0:MAX_W-1];
  bit               line_older  [0:MAX_W-1];
  logic [8:0]       window_q;
  int unsigned      next_col;
  int unsigned      next_row;

  int          error_count = 0;
  int unsigned cycle_count = 0;
  int          hold_left = 0;
  bit          sender_idle_en = 1'b1;
  bit          recv_idle_en = 1'b1;

  cellular_automaton_smoothing_pass #(.MAX_WIDTH(MAX_W)) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cell_wall (in_cell_wall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_col      (out_col),
    .out_row      (out_row),
    .out_wall     (out_wall),
    .out_run_last (out_run_last)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < MIN_DIM) return 32'(MIN_DIM);
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  function automatic int unsigned grid_cells();
    return clamp_dim(grid_w_reg, MAX_W) * clamp_dim(grid_h_reg, 32'(HEIGHT_LIMIT));
  endfunction

  function automatic void restart_grid();
    window_q = '0;
    next_col = 0;
    next_row = 0;
  endfunction

  // Appends one expected result word
  function automatic void expect_update(input cell_update_t upd);
    pending_updates.insert(pending_updates.size(), upd);
  endfunction

  // Any write to a known index starts a fresh grid; others are dropped
  function automatic void smooth_apply_reg(input logic [IDX_W-1:0] idx,
                                           input logic [CFG_W-1:0] val);
    case (idx)
      REG_GRID_WIDTH: begin
        grid_w_reg = val;
        restart_grid();
      end
      REG_GRID_HEIGHT: begin
        grid_h_reg = val;
        restart_grid();
      end
      REG_WALL_THRESHOLD: begin
        thresh_reg = val[THR_W-1:0];
        restart_grid();
      end
      default: ;
    endcase
  endfunction

  // Works out the result words caused by one accepted cell
  function automatic void smooth_predict(input logic cell_bit);
    int unsigned  w, h, c, r, ring_walls;
    logic         int_v, brd_v;
    cell_update_t upd;
    w = clamp_dim(grid_w_reg, MAX_W);
    h = clamp_dim(grid_h_reg, 32'(HEIGHT_LIMIT));
    if (next_col >= w || next_row >= h) restart_grid();
    c = next_col;
    r = next_row;
    // new column enters at the top: this row, row above, two rows above
    window_q = {cell_bit, line_recent[c], line_older[c], window_q[8:3]};
    line_older[c]  = line_recent[c];
    line_recent[c] = cell_bit;
    int_v = (c >= 2) && (r >= 2);
    brd_v = (c == 0) || (c == w - 1) || (r == 0) || (r == h - 1);
    // interior cell one row and one column behind
    if (int_v) begin
      ring_walls = $countones(window_q & RING_MASK);
      upd.col  = COL_W'(c - 1);
      upd.row  = ROW_W'(r - 1);
      upd.wall = (ring_walls >= thresh_reg);
      upd.last = !brd_v;
      expect_update(upd);
    end
    // border cell passes straight through
    if (brd_v) begin
      upd.col  = COL_W'(c);
      upd.row  = ROW_W'(r);
      upd.wall = cell_bit;
      upd.last = 1'b1;
      expect_update(upd);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    next_col = c;
    next_row = r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin
    cell_update_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_updates.size() == 0) begin
        report_mismatch($sformatf("unexpected word col %0d row %0d", out_col, out_row));
      end else begin
        want = pending_updates.pop_front();
        if (out_col !== want.col || out_row !== want.row || out_wall !== want.wall ||
            out_run_last !== want.last)
          report_mismatch($sformatf(
            "got col %0d row %0d wall %b last %b, want col %0d row %0d wall %b last %b",
            out_col, out_row, out_wall, out_run_last,
            want.col, want.row, want.wall, want.last));
      end
    end
  end

  // Receiver: long hold-offs first, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= recv_idle_en && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one cell word and hold it until taken
  task automatic send_cell(input logic wall_bit);
    while (sender_idle_en && ($urandom_range(99) < IDLE_PCT)) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_cell_wall <= wall_bit;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    smooth_predict(wall_bit);
  endtask

  task automatic stream_cells(input int count, input int density);
    for (int i = 0; i < count; i++) send_cell($urandom_range(99) < density);
  endtask

  // 3x3 grid, bit i is cell (i % 3, i / 3)
  task automatic send_pattern(input logic [8:0] p);
    for (int i = 0; i < 9; i++) send_cell(p[i]);
  endtask

  // Drop valid, wait for every expected word, then let the pipe settle
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    smooth_apply_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset geometry: the top row and the start of the next
  task automatic test_reset_defaults();
    stream_cells(RESET_CELLS, 45);
    wait_drained();
  endtask

  // Smallest grid via clamping, threshold at zero, eight and above eight
  task automatic test_tiny_grids();
    write_reg(REG_GRID_WIDTH, '0);
    write_reg(REG_GRID_HEIGHT, '0);
    write_reg(REG_WALL_THRESHOLD, '0);
    send_pattern(9'h000);
    wait_drained();
    write_reg(REG_WALL_THRESHOLD, 11'd8);
    send_pattern(9'h1EF);
    wait_drained();
    // upper data bits are ignored, threshold 15 keeps every interior cell floor
    write_reg(REG_WALL_THRESHOLD, 11'h7FF);
    send_pattern(9'h1FF);
    wait_drained();
  endtask

  // Write to a missing index mid-grid must not restart the grid
  task automatic test_unused_index();
    write_reg(REG_GRID_WIDTH, 11'd6);
    write_reg(REG_GRID_HEIGHT, 11'd4);
    write_reg(REG_WALL_THRESHOLD, 11'd3);
    stream_cells(10, 50);
    wait_drained();
    write_reg(REG_NONE, 11'h7FF);
    stream_cells(14, 50);
    wait_drained();
  endtask

  // Width register at all ones, clamped to the widest line; start of the top row
  task automatic test_wide_grid();
    write_reg(REG_GRID_WIDTH, 11'h7FF);
    write_reg(REG_GRID_HEIGHT, 11'd3);
    write_reg(REG_WALL_THRESHOLD, 11'd4);
    stream_cells(WIDE_CELLS, 50);
    wait_drained();
  endtask

  // Tallest grid, narrowest width; first few rows
  task automatic test_tall_grid();
    write_reg(REG_GRID_WIDTH, 11'd3);
    write_reg(REG_GRID_HEIGHT, 11'd1024);
    write_reg(REG_WALL_THRESHOLD, 11'd3);
    stream_cells(TALL_CELLS, 50);
    wait_drained();
  endtask

  // Receiver holds off while the sender keeps going, so the input stalls
  task automatic test_backpressure();
    write_reg(REG_GRID_WIDTH, 11'd6);
    write_reg(REG_GRID_HEIGHT, 11'd4);
    write_reg(REG_WALL_THRESHOLD, 11'd5);
    sender_idle_en = 1'b0;
    hold_left = 150;
    stream_cells(2 * grid_cells(), 55);
    sender_idle_en = 1'b1;
    wait_drained();
  endtask

  // Random geometry and content; mostly whole grids, some cut short
  task automatic test_random_grids();
    int sent_cells;
    int round;
    int n;
    int density;
    bit quiet;
    logic [CFG_W-1:0] w_raw, h_raw;
    logic [THR_W-1:0] thr;
    sent_cells = 0;
    round = 0;
    while (sent_cells < RANDOM_CELLS || round < 3) begin
      if (round == 0 || $urandom_range(3) != 0) begin
        w_raw = ($urandom_range(7) == 0) ? CFG_W'($urandom_range(0, 2))
                                         : CFG_W'($urandom_range(3, 8));
        h_raw = ($urandom_range(7) == 0) ? CFG_W'($urandom_range(0, 2))
                                         : CFG_W'($urandom_range(3, 6));
        thr   = ($urandom_range(5) == 0) ? THR_W'($urandom_range(9, 15))
                                         : THR_W'($urandom_range(0, 8));
        write_reg(REG_GRID_WIDTH, w_raw);
        write_reg(REG_GRID_HEIGHT, h_raw);
        write_reg(REG_WALL_THRESHOLD, {7'($urandom), thr});
      end
      // one stretch with no idling on either side
      quiet = (round == 2);
      sender_idle_en = !quiet;
      recv_idle_en   = !quiet;
      case ($urandom_range(5))
        0:       density = 0;
        1:       density = 100;
        default: density = $urandom_range(20, 80);
      endcase
      if (quiet) n = 2 * grid_cells();
      else if ($urandom_range(5) == 0) n = $urandom_range(1, grid_cells() - 1);
      else n = grid_cells() * $urandom_range(1, 2);
      stream_cells(n, density);
      sent_cells += n;
      wait_drained();
      sender_idle_en = 1'b1;
      recv_idle_en   = 1'b1;
      round++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_cell_wall = 1'b0;
    out_stall    = 1'b0;
    grid_w_reg   = RST_GRID_WIDTH;
    grid_h_reg   = RST_GRID_HEIGHT;
    thresh_reg   = RST_WALL_THRESHOLD;
    for (int i = 0; i < MAX_W; i++) begin
      line_recent[i] = 1'b0;
      line_older[i]  = 1'b0;
    end
    restart_grid();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_tiny_grids();
    test_unused_index();
    test_wide_grid();
    test_tall_grid();
    test_backpressure();
    test_random_grids();

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/cacsp_pkg.sv
sv/cacsp_front.sv
sv/cacsp_queue.sv
sv/cacsp_back.sv
sv/cellular_automaton_smoothing_pass.sv
tb/tb_cellular_automaton_smoothing_pass.sv
